>>> rtl/core/dmkv_pkg.sv
// ----------------------------------------------------------------------------
// dmkv_pkg
// shared types and constants of the direct-mapped key/value cache
// ----------------------------------------------------------------------------
package dmkv_pkg;

  localparam int KEY_W       = 64;
  localparam int DATA_W      = 64;
  localparam int CNT_W       = 64;
  localparam int TYPE_W      = 3;
  localparam int PCT_W       = 7;
  localparam int EPOCH_W     = 8;
  localparam int DIV_CNT_W   = $clog2(KEY_W);
  localparam int PERCENT_SCALE = 100;

  // request codes, six and seven mean nothing
  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_LOOKUP     = 3'd1,
    REQ_INVALIDATE = 3'd2,
    REQ_CLEAR      = 3'd3,
    REQ_STATS_RD   = 3'd4,
    REQ_STATS_CLR  = 3'd5
  } req_type_t;

  localparam logic STATUS_ACK  = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic ram_rd;
    logic div_start;
    logic commit;
    logic sweep;
  } dmkv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              mod_done;
    logic              div_done;
    logic              epoch_wrap;
    logic              sweep_last;
    logic              out_free;
    logic [TYPE_W-1:0] req_type;
  } dmkv_status_t;

endpackage

>>> rtl/core/dmkv_req_if.sv
// ----------------------------------------------------------------------------
// dmkv_req_if
// request channel: valid/ready handshake with one request word
// ----------------------------------------------------------------------------
interface dmkv_req_if
  import dmkv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [KEY_W-1:0]  req_key;
  logic [DATA_W-1:0] req_value;

  modport source (output valid, req_type, req_key, req_value, input ready);
  modport sink   (input valid, req_type, req_key, req_value, output ready);
endinterface

>>> rtl/core/dmkv_rsp_if.sv
// ----------------------------------------------------------------------------
// dmkv_rsp_if
// result channel: valid/ready handshake with one result word
// ----------------------------------------------------------------------------
interface dmkv_rsp_if
  import dmkv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              status;
  logic [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  miss_count;
  logic [CNT_W-1:0]  eviction_count;
  logic [PCT_W-1:0]  hit_percent;

  modport source (output valid, status, read_value, hit_count, miss_count,
                  eviction_count, hit_percent, input ready);
  modport sink   (input valid, status, read_value, hit_count, miss_count,
                  eviction_count, hit_percent, output ready);
endinterface

>>> rtl/core/dmkv_ram.sv
// ----------------------------------------------------------------------------
// dmkv_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module dmkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/dmkv_ctrl.sv
// ----------------------------------------------------------------------------
// dmkv_ctrl
// request sequencer: accept, index, read or divide, execute, sweep
// ----------------------------------------------------------------------------
module dmkv_ctrl
  import dmkv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  dmkv_status_t stat,
  output dmkv_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_IDX,
    ST_DIV,
    ST_EX
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        if (stat.mod_done) begin
          if (stat.req_type == REQ_STATS_RD) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            cmd.ram_rd = 1'b1;
            state_nxt  = ST_EX;
          end
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_EX;
        end
      end
      ST_EX: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          if (stat.req_type == REQ_CLEAR && stat.epoch_wrap) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready_r |-> state_r == ST_IDLE)
    else $error("ready outside idle");

  a_load_to_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_IDX)
    else $error("accepted request not indexed");

  a_ex_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EX && stat.out_free) |=> state_r != ST_EX)
    else $error("execute repeated");

endmodule

>>> rtl/core/dmkv_dp.sv
// ----------------------------------------------------------------------------
// dmkv_dp
// datapath: request registers, slot index, table ram, counters, divider,
// result register
// ----------------------------------------------------------------------------
module dmkv_dp
  import dmkv_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dmkv_cmd_t         cmd,
  output dmkv_status_t      stat,
  input  logic [TYPE_W-1:0] in_type,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic [DATA_W-1:0] out_read_value,
  output logic [CNT_W-1:0]  out_hit_count,
  output logic [CNT_W-1:0]  out_miss_count,
  output logic [CNT_W-1:0]  out_eviction_count,
  output logic [PCT_W-1:0]  out_hit_percent
);

  localparam int IW     = $clog2(ENTRIES);
  localparam bit POW2   = (ENTRIES & (ENTRIES - 1)) == 0;
  localparam int WORD_W = EPOCH_W + KEY_W + DATA_W;
  localparam logic [IW:0] IDX_LIM = (IW + 1)'(ENTRIES);
  localparam logic [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

  // request registers
  logic [TYPE_W-1:0] type_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r  <= in_type;
      key_r   <= in_key;
      value_r <= in_value;
    end
  end

  // slot index: key mod entries
  logic [IW-1:0] idx;
  logic          mod_done;

  if (POW2) begin : g_idx_mask
    assign idx      = key_r[IW-1:0];
    assign mod_done = 1'b1;
  end else begin : g_idx_mod
    // eight key bits per cycle, msb first, one compare-subtract per bit
    logic [IW-1:0]   rem_r, rem_nxt;
    logic [KEY_W-1:0] ksh_r;
    logic [2:0]      step_r;
    logic            busy_r;
    logic [IW:0]     trial;

    always_comb begin
      rem_nxt = rem_r;
      trial   = '0;
      for (int j = 0; j < 8; j++) begin
        trial = {rem_nxt, ksh_r[KEY_W-1-j]};
        if (trial >= IDX_LIM) begin
          trial = trial - IDX_LIM;
        end
        rem_nxt = trial[IW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        step_r <= '0;
      end else if (cmd.load) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        rem_r <= '0;
        ksh_r <= in_key;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        ksh_r <= {ksh_r[KEY_W-9:0], 8'h00};
      end
    end

    assign idx      = rem_r;
    assign mod_done = !busy_r;
  end

  // epoch and clearing sweep
  logic [EPOCH_W-1:0] epoch_r;
  logic [IW-1:0]      swp_r;
  logic               commit_clear;

  assign commit_clear = cmd.commit && (type_r == REQ_CLEAR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= EPOCH_W'(1);
      swp_r   <= '0;
    end else begin
      if (commit_clear) begin
        if (epoch_r == '1) begin
          epoch_r <= EPOCH_W'(1);
        end else begin
          epoch_r <= epoch_r + EPOCH_W'(1);
        end
      end
      if (cmd.sweep) begin
        if (swp_r == IDX_LAST) begin
          swp_r <= '0;
        end else begin
          swp_r <= swp_r + IW'(1);
        end
      end
    end
  end

  // table ram: {epoch, key, value}, epoch zero marks an empty slot
  logic              ram_we;
  logic [IW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic              slot_live;
  logic              slot_hit;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = cmd.sweep ? swp_r : idx;
    if (cmd.sweep) begin
      ram_we = 1'b1;
    end else if (cmd.commit && type_r == REQ_INSERT) begin
      ram_we    = 1'b1;
      ram_wdata = {epoch_r, key_r, value_r};
    end else if (cmd.commit && type_r == REQ_INVALIDATE) begin
      ram_we    = 1'b1;
      ram_wdata = {{EPOCH_W{1'b0}}, key_r, value_r};
    end
  end

  dmkv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (cmd.ram_rd),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign slot_live = ram_rdata[WORD_W-1 -: EPOCH_W] == epoch_r;
  assign slot_hit  = slot_live && (ram_rdata[KEY_W+DATA_W-1 -: KEY_W] == key_r);

  // counters
  logic [CNT_W-1:0] hits_r, misses_r, evicts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else if (cmd.commit) begin
      case (type_r)
        REQ_INSERT: begin
          if (slot_live) begin
            evicts_r <= evicts_r + CNT_W'(1);
          end
        end
        REQ_LOOKUP: begin
          if (slot_hit) begin
            hits_r <= hits_r + CNT_W'(1);
          end else begin
            misses_r <= misses_r + CNT_W'(1);
          end
        end
        REQ_STATS_CLR: begin
          hits_r   <= '0;
          misses_r <= '0;
          evicts_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // restoring divider for the hit rate, one quotient bit per cycle
  logic [CNT_W-1:0]     div_rem_r, div_q_r, div_d_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 div_busy_r;
  logic [CNT_W:0]       div_trial;
  logic                 div_ge;
  logic [CNT_W-1:0]     scaled_hits, lookup_total;

  assign scaled_hits  = (hits_r << 6) + (hits_r << 5) + (hits_r << 2);
  assign lookup_total = hits_r + misses_r;
  assign div_trial    = {div_rem_r, div_q_r[CNT_W-1]};
  assign div_ge       = div_trial >= {1'b0, div_d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= (lookup_total != '0);
      div_cnt_r  <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      if (div_cnt_r == '1) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem_r <= '0;
      div_d_r   <= lookup_total;
      div_q_r   <= (lookup_total != '0) ? scaled_hits : '0;
    end else if (div_busy_r) begin
      div_rem_r <= div_ge ? CNT_W'(div_trial - {1'b0, div_d_r}) : div_trial[CNT_W-1:0];
      div_q_r   <= {div_q_r[CNT_W-2:0], div_ge};
    end
  end

  // result register
  logic              out_valid_r;
  logic              out_status_r;
  logic [DATA_W-1:0] out_value_r;
  logic [CNT_W-1:0]  out_hits_r, out_misses_r, out_evicts_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic              out_free;
  logic [PCT_W-1:0]  pct_sat;

  assign out_free = !out_valid_r || out_ready;
  assign pct_sat  = (div_q_r > CNT_W'(PERCENT_SCALE)) ? PCT_W'(PERCENT_SCALE)
                                                      : div_q_r[PCT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= STATUS_ACK;
      out_value_r  <= '0;
      out_hits_r   <= '0;
      out_misses_r <= '0;
      out_evicts_r <= '0;
      out_pct_r    <= '0;
      case (type_r)
        REQ_LOOKUP: begin
          if (slot_hit) begin
            out_value_r <= ram_rdata[DATA_W-1:0];
          end else begin
            out_status_r <= STATUS_MISS;
          end
        end
        REQ_STATS_RD: begin
          out_hits_r   <= hits_r;
          out_misses_r <= misses_r;
          out_evicts_r <= evicts_r;
          out_pct_r    <= pct_sat;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_value_r;
  assign out_hit_count      = out_hits_r;
  assign out_miss_count     = out_misses_r;
  assign out_eviction_count = out_evicts_r;
  assign out_hit_percent    = out_pct_r;

  always_comb begin
    stat            = '0;
    stat.mod_done   = mod_done;
    stat.div_done   = !div_busy_r;
    stat.epoch_wrap = (epoch_r == '1);
    stat.sweep_last = (swp_r == IDX_LAST);
    stat.out_free   = out_free;
    stat.req_type   = type_r;
  end

  a_commit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result lost");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ram_rd && mod_done) |-> ({1'b0, idx} < IDX_LIM))
    else $error("slot index out of range");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch reached the empty mark");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(div_busy_r) |-> $past(div_cnt_r) == '1)
    else $error("divider stopped early");

endmodule

>>> rtl/core/direct_mapped_key_value_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_key_value_cache
// direct-mapped key/value cache with hit, miss and eviction counters
// ----------------------------------------------------------------------------
// usage
//   in_req carries one request word (type, key, value), out_rsp one result
//   word per request, both on valid/ready; a word moves when both are high
//   one request is worked at a time: in_req.ready is high only while idle
//   per request: accept, slot index, table read (or the divider for a stats
//   read), execute; when ENTRIES is a power of two the slot index is the low
//   key bits, otherwise it is reduced serially, 8 key bits a cycle
//   a stats read runs the serial divider for the hit rate; the divider is
//   skipped when no lookup has been counted yet
//   a clear steps the slot epoch; on every 255th clear the slot epoch wraps
//   and a sweep rewrites all ENTRIES slots
//   after reset the same sweep runs first: in_req.ready stays low until it
//   ends, counters come up zero
//   a result waits in the output register while out_rsp.ready is low; the
//   next request may be accepted meanwhile and then holds in its execute
//   step until the output register frees up
//   unused request codes give an all-zero result and change nothing
// ----------------------------------------------------------------------------
module direct_mapped_key_value_cache
  import dmkv_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  dmkv_req_if.sink   in_req,
  dmkv_rsp_if.source out_rsp
);

  // control and status between sequencer and datapath
  dmkv_cmd_t    cmd;
  dmkv_status_t stat;
  logic         in_ready;

  // sequencer: idle, index, read or divide, execute, sweep
  dmkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_req.ready = in_ready;

  // datapath: table ram, counters, divider and output register
  dmkv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_type            (in_req.req_type),
    .in_key             (in_req.req_key),
    .in_value           (in_req.req_value),
    .out_valid          (out_rsp.valid),
    .out_ready          (out_rsp.ready),
    .out_status         (out_rsp.status),
    .out_read_value     (out_rsp.read_value),
    .out_hit_count      (out_rsp.hit_count),
    .out_miss_count     (out_rsp.miss_count),
    .out_eviction_count (out_rsp.eviction_count),
    .out_hit_percent    (out_rsp.hit_percent)
  );

endmodule
